[hdl/jsu_pkg.sv]
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STR,
		PH_ESC,
		PH_HEX1,
		PH_HELD,
		PH_HELDESC,
		PH_HEX2
	} phase_t;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [15:0] CAP_RESET = 16'd2048;
	localparam int unsigned MAX_RES = 6;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [15:0] HI_SUR_LO = 16'hD800;
	localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SUR_LO = 16'hDC00;
	localparam logic [15:0] LO_SUR_HI = 16'hDFFF;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic hex_t hexval(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.ok  = 1'b1;
			h.val = 4'(c[2:0] + 3'd1) + 4'd8;
		end
		return h;
	endfunction

	// b[0] is the lead byte; len of zero means not encodable
	function automatic utf8_t utf8(input logic [20:0] cp);
		utf8_t e;
		e = '0;
		if (cp <= 21'h7F) begin
			e.len  = 3'd1;
			e.b[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			e.len  = 3'd2;
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			e.len  = 3'd3;
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
		end else if (cp <= 21'h10FFFF) begin
			e.len  = 3'd4;
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

[hdl/jsu_if.sv]
// Valid/ready channel interfaces for input bytes and decoded results.
interface jsu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_flag;

	modport source (output valid, output in_byte, output start_flag, input ready);
	modport sink (input valid, input in_byte, input start_flag, output ready);
endinterface

interface jsu_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, output out_byte, output kind, output last, input ready);
	modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

[hdl/json_string_unescape_to_utf8.sv]
// JSON string unescaper: decodes one input beat per cycle into UTF-8 result beats.
// Latency: the first result of a byte is offered the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and the
// results are taken as offered; a byte giving more (up to 6) holds the input until
// the result buffer drains. Reset: decoder idle, capacity 2048, buffer empty.
module json_string_unescape_to_utf8 (
	input  logic          clk,
	input  logic          arst_n,
	jsu_byte_if.sink      chars,
	jsu_result_if.source  results,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_STR,
		ACT_ESC,
		ACT_UNIT,
		ACT_CP,
		ACT_FAIL
	} act_t;

	phase_t      phase_q;
	logic [15:0] hex_q;
	logic [1:0]  dig_q;
	logic [15:0] high_q;
	logic [15:0] ocnt_q;
	logic [15:0] cap_q;

	logic [7:0]  buf_byte_q [MAX_RES];
	logic [1:0]  buf_kind_q [MAX_RES];
	logic [2:0]  buf_cnt_q;

	phase_t      ph_d;
	logic [15:0] hex_d;
	logic [1:0]  dig_d;
	logic [15:0] high_d;
	logic [15:0] ocnt_d;
	logic [7:0]  rb [MAX_RES];
	logic [1:0]  rk [MAX_RES];
	logic [2:0]  rn;

	logic in_fire;
	logic out_fire;

	assign out_fire      = results.valid && results.ready;
	assign chars.ready   = (buf_cnt_q == 3'd0) || (out_fire && buf_cnt_q == 3'd1);
	assign in_fire       = chars.valid && chars.ready;
	assign results.valid = buf_cnt_q != 3'd0;
	assign results.last  = buf_cnt_q == 3'd1;
	assign results.out_byte = buf_byte_q[0];
	assign results.kind  = buf_kind_q[0];

	always_comb begin
		logic [7:0]  c;
		logic [16:0] oc;
		logic [16:0] cap;
		hex_t        hv;
		act_t        act;
		logic        held;
		logic        do_fail;
		logic        do_done;
		logic        pb;
		logic [7:0]  pbv;
		logic        pc;
		logic [20:0] cpv;
		utf8_t       enc;
		utf8_t       enc_h;

		c       = chars.in_byte;
		cap     = {1'b0, cap_q};
		oc      = {1'b0, ocnt_q};
		hv      = hexval(c);
		act     = ACT_NONE;
		held    = 1'b0;
		do_fail = 1'b0;
		do_done = 1'b0;
		pb      = 1'b0;
		pbv     = '0;
		pc      = 1'b0;
		cpv     = '0;
		ph_d    = phase_q;
		hex_d   = hex_q;
		dig_d   = dig_q;
		high_d  = high_q;
		rn      = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			rb[i] = '0;
			rk[i] = KIND_DATA;
		end

		if (chars.start_flag) begin
			hex_d  = '0;
			dig_d  = '0;
			high_d = '0;
			oc     = '0;
			ph_d   = PH_STR;
			if (c != CH_QUOTE || cap_q == 16'd0)
				act = ACT_FAIL;
		end else begin
			case (phase_q)
				PH_STR: act = ACT_STR;
				PH_ESC: act = ACT_ESC;
				PH_HEX1: begin
					if (!hv.ok) begin
						act = ACT_FAIL;
					end else begin
						hex_d = {hex_q[11:0], hv.val};
						if (dig_q == 2'd3) begin
							act = ACT_UNIT;
							cpv = {5'd0, hex_d};
						end else begin
							dig_d = dig_q + 2'd1;
						end
					end
				end
				PH_HELD: begin
					if (c == CH_BSLASH) begin
						ph_d = PH_HELDESC;
					end else begin
						held = 1'b1;
						act  = ACT_STR;
					end
				end
				PH_HELDESC: begin
					if (c == CH_U) begin
						ph_d  = PH_HEX2;
						hex_d = '0;
						dig_d = '0;
					end else begin
						held = 1'b1;
						act  = ACT_ESC;
					end
				end
				PH_HEX2: begin
					if (!hv.ok) begin
						held = 1'b1;
						act  = ACT_FAIL;
					end else begin
						hex_d = {hex_q[11:0], hv.val};
						if (dig_q == 2'd3) begin
							ph_d = PH_STR;
							if (hex_d >= LO_SUR_LO && hex_d <= LO_SUR_HI) begin
								act = ACT_CP;
								cpv = 21'h10000 + {1'b0, high_q[9:0], hex_d[9:0]};
							end else begin
								held = 1'b1;
								act  = ACT_UNIT;
								cpv  = {5'd0, hex_d};
							end
						end else begin
							dig_d = dig_q + 2'd1;
						end
					end
				end
				default: ph_d = PH_IDLE;
			endcase
		end

		// held high surrogate goes out ahead of whatever this byte does
		enc_h = utf8({5'd0, high_q});
		if (held) begin
			ph_d = PH_STR;
			if (enc_h.len != 3'd0 && oc + 17'(enc_h.len) < cap) begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < enc_h.len) begin
						rb[rn] = enc_h.b[i];
						rn     = rn + 3'd1;
					end
				end
				oc = oc + 17'(enc_h.len);
			end else begin
				act     = ACT_NONE;
				do_fail = 1'b1;
			end
		end

		case (act)
			ACT_STR: begin
				ph_d = PH_STR;
				if (c == CH_NUL)
					do_fail = 1'b1;
				else if (c == CH_QUOTE)
					do_done = 1'b1;
				else if (c == CH_BSLASH)
					ph_d = PH_ESC;
				else begin
					pb  = 1'b1;
					pbv = c;
				end
			end
			ACT_ESC: begin
				ph_d = PH_STR;
				if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
					pb  = 1'b1;
					pbv = c;
				end else if (c == CH_N) begin
					pb  = 1'b1;
					pbv = 8'h0A;
				end else if (c == CH_R) begin
					pb  = 1'b1;
					pbv = 8'h0D;
				end else if (c == CH_T) begin
					pb  = 1'b1;
					pbv = 8'h09;
				end else if (c == CH_B) begin
					pb  = 1'b1;
					pbv = 8'h08;
				end else if (c == CH_F) begin
					pb  = 1'b1;
					pbv = 8'h0C;
				end else if (c == CH_U) begin
					ph_d  = PH_HEX1;
					hex_d = '0;
					dig_d = '0;
				end else begin
					do_fail = 1'b1;
				end
			end
			ACT_UNIT: begin
				ph_d = PH_STR;
				if (cpv[15:0] >= HI_SUR_LO && cpv[15:0] <= HI_SUR_HI) begin
					high_d = cpv[15:0];
					ph_d   = PH_HELD;
				end else begin
					pc = 1'b1;
				end
			end
			ACT_CP: begin
				ph_d = PH_STR;
				pc   = 1'b1;
			end
			ACT_FAIL: do_fail = 1'b1;
			default: ;
		endcase

		if (pb) begin
			if (oc + 17'd1 < cap) begin
				rb[rn] = pbv;
				rn     = rn + 3'd1;
				oc     = oc + 17'd1;
			end else begin
				do_fail = 1'b1;
			end
		end

		enc = utf8(cpv);
		if (pc) begin
			if (enc.len != 3'd0 && oc + 17'(enc.len) < cap) begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < enc.len) begin
						rb[rn] = enc.b[i];
						rn     = rn + 3'd1;
					end
				end
				oc = oc + 17'(enc.len);
			end else begin
				do_fail = 1'b1;
			end
		end

		if (do_fail) begin
			rk[rn] = KIND_ERROR;
			rn     = rn + 3'd1;
			ph_d   = PH_IDLE;
		end else if (do_done) begin
			rk[rn] = KIND_DONE;
			rn     = rn + 3'd1;
			ph_d   = PH_IDLE;
		end

		ocnt_d = oc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= '0;
			dig_q   <= '0;
			high_q  <= '0;
			ocnt_q  <= '0;
		end else if (in_fire) begin
			phase_q <= ph_d;
			hex_q   <= hex_d;
			dig_q   <= dig_d;
			high_q  <= high_d;
			ocnt_q  <= ocnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (in_fire) begin
			buf_cnt_q <= rn;
		end else if (out_fire) begin
			buf_cnt_q <= buf_cnt_q - 3'd1;
		end
	end

	// result buffer loads on every input beat, else shifts towards entry 0 on every output beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MAX_RES; i++) begin
				buf_byte_q[i] <= rb[i];
				buf_kind_q[i] <= rk[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_byte_q[i] <= buf_byte_q[i + 1];
				buf_kind_q[i] <= buf_kind_q[i + 1];
			end
		end
	end

endmodule

[hdl/jsu_checker.sv]
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] kind,
	input logic       last
);
	import jsu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(last))
		else $error("result beat changed while stalled");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_DATA || kind == KIND_DONE || kind == KIND_ERROR))
		else $error("unknown result kind");

	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> last && out_byte == 8'h00)
		else $error("done or error beat not final or carries data");

	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(out_ready && last) |-> !in_ready)
		else $error("input taken while earlier results pending");

	// in_valid is observed for completeness of the channel view
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready || !in_valid)
		else $error("input stalled with empty result buffer");

endmodule

bind json_string_unescape_to_utf8 jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_byte  (results.out_byte),
	.kind      (results.kind),
	.last      (results.last)
);
